// ----- src/dabd_pkg.sv -----
// Shared widths, register map and item type for the detection argmax box decoder.
package dabd_pkg;

    localparam int NUM_CLASSES = 80;
    localparam int LABEL_W     = 7;
    localparam int SCORE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int LIMIT_W     = 12;
    localparam int FRAC_PX_W   = 4;
    localparam int SPAN_W      = COORD_W + 2;
    localparam int PROD_W      = SPAN_W + COORD_W;
    localparam int PROD_SHIFT  = 17;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [LABEL_W-1:0] LAST_POS = LABEL_W'(NUM_CLASSES - 1);

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_PIXELS_PER_UNIT = 2'd0;
    localparam logic [1:0] REG_MAX_COL         = 2'd1;
    localparam logic [1:0] REG_MAX_ROW         = 2'd2;
    localparam logic [1:0] REG_SCORE_THRESHOLD = 2'd3;

    localparam logic [COORD_W-1:0] RST_PIXELS_PER_UNIT = 16'd10240;
    localparam logic [LIMIT_W-1:0] RST_MAX_COL         = 12'd639;
    localparam logic [LIMIT_W-1:0] RST_MAX_ROW         = 12'd639;
    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd32768;

    typedef struct packed {
        logic [SCORE_W-1:0] class_score;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
        logic               last_class;
        logic               last_query;
    } t_item;

endpackage

// ----- src/dabd_edge.sv -----
// One box corner: centre -/+ half size, scaled to Q12.4 pixels and clipped.
module dabd_edge (
    input  logic [dabd_pkg::COORD_W-1:0] i_centre,
    input  logic [dabd_pkg::COORD_W-1:0] i_size,
    input  logic                         i_near,
    input  logic [dabd_pkg::LIMIT_W-1:0] i_limit,
    input  logic [dabd_pkg::COORD_W-1:0] i_scale,
    output logic [dabd_pkg::COORD_W-1:0] o_px
);

    logic [dabd_pkg::COORD_W:0]                        twice;
    logic                                              non_pos;
    logic [dabd_pkg::SPAN_W-1:0]                       span;
    logic [dabd_pkg::PROD_W-1:0]                       prod;
    logic [dabd_pkg::PROD_W-dabd_pkg::PROD_SHIFT-1:0]  px;
    logic [dabd_pkg::COORD_W-1:0]                      cap;

    // Edge in units of 2^-17: 2*centre -/+ size
    assign twice   = {i_centre, 1'b0};
    assign non_pos = i_near && (twice <= {1'b0, i_size});
    assign span    = i_near ? ({1'b0, twice} - {2'b00, i_size})
                            : ({1'b0, twice} + {2'b00, i_size});

    assign prod = {{dabd_pkg::COORD_W{1'b0}}, span}
                * {{dabd_pkg::SPAN_W{1'b0}}, i_scale};
    assign px   = prod[dabd_pkg::PROD_W-1:dabd_pkg::PROD_SHIFT];
    assign cap  = {i_limit, {dabd_pkg::FRAC_PX_W{1'b0}}};

    always_comb begin
        if (non_pos) begin
            o_px = '0;
        end else if (px > {1'b0, cap}) begin
            o_px = cap;
        end else begin
            o_px = px[dabd_pkg::COORD_W-1:0];
        end
    end

endmodule

// ----- src/detection_argmax_box_decode_top.sv -----
// Top level: streaming class argmax and box corner decode with APB register port.
// A closing score word passes the input register, then the result register.
// Throughput: one score word per cycle, except while a closing word waits for
//   a free result slot; the argmax compare and four independent 18x16 corner
//   multiplies sit between the input and result registers.
// Reset (sync, active low) clears valids and argmax state, loads register defaults.
module detection_argmax_box_decode_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // score stream
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [dabd_pkg::SCORE_W-1:0]   i_class_score,
    input  logic [dabd_pkg::COORD_W-1:0]   i_center_x,
    input  logic [dabd_pkg::COORD_W-1:0]   i_center_y,
    input  logic [dabd_pkg::COORD_W-1:0]   i_box_width,
    input  logic [dabd_pkg::COORD_W-1:0]   i_box_height,
    input  logic                           i_last_class,
    input  logic                           i_last_query,
    // detection results
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_kept,
    output logic [dabd_pkg::LABEL_W-1:0]   o_label,
    output logic [dabd_pkg::SCORE_W-1:0]   o_best_confidence,
    output logic [dabd_pkg::COORD_W-1:0]   o_left_px,
    output logic [dabd_pkg::COORD_W-1:0]   o_top_px,
    output logic [dabd_pkg::COORD_W-1:0]   o_right_px,
    output logic [dabd_pkg::COORD_W-1:0]   o_bottom_px,
    output logic                           o_frame_done,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dabd_pkg::PADDR_W-1:0]   paddr,
    input  logic [dabd_pkg::PDATA_W-1:0]   pwdata,
    output logic [dabd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dabd_pkg::COORD_W-1:0] r_pixels_per_unit;
    logic [dabd_pkg::LIMIT_W-1:0] r_max_col;
    logic [dabd_pkg::LIMIT_W-1:0] r_max_row;
    logic [dabd_pkg::SCORE_W-1:0] r_score_threshold;
    logic                         cfg_wr;
    logic [1:0]                   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixels_per_unit <= dabd_pkg::RST_PIXELS_PER_UNIT;
            r_max_col         <= dabd_pkg::RST_MAX_COL;
            r_max_row         <= dabd_pkg::RST_MAX_ROW;
            r_score_threshold <= dabd_pkg::RST_SCORE_THRESHOLD;
        end else if (cfg_wr) begin
            case (cfg_idx)
                dabd_pkg::REG_PIXELS_PER_UNIT: begin
                    r_pixels_per_unit <= pwdata[dabd_pkg::COORD_W-1:0];
                end
                dabd_pkg::REG_MAX_COL: begin
                    r_max_col <= pwdata[dabd_pkg::LIMIT_W-1:0];
                end
                dabd_pkg::REG_MAX_ROW: begin
                    r_max_row <= pwdata[dabd_pkg::LIMIT_W-1:0];
                end
                dabd_pkg::REG_SCORE_THRESHOLD: begin
                    r_score_threshold <= pwdata[dabd_pkg::SCORE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read back zero-extended; read data is combinational since pready is tied high
    always_comb begin
        case (cfg_idx)
            dabd_pkg::REG_PIXELS_PER_UNIT: begin
                prdata = dabd_pkg::PDATA_W'(r_pixels_per_unit);
            end
            dabd_pkg::REG_MAX_COL: begin
                prdata = dabd_pkg::PDATA_W'(r_max_col);
            end
            dabd_pkg::REG_MAX_ROW: begin
                prdata = dabd_pkg::PDATA_W'(r_max_row);
            end
            dabd_pkg::REG_SCORE_THRESHOLD: begin
                prdata = dabd_pkg::PDATA_W'(r_score_threshold);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    dabd_pkg::t_item r_s1;
    logic            r_s1_vld;
    logic            out_free;
    logic            s1_go;
    logic            in_take;

    // The output slot is free when empty or when its word leaves this cycle.
    assign out_free = !o_out_valid || i_out_ready;
    // Only a closing word needs the output slot; plain scores always drain.
    assign s1_go    = r_s1_vld && (!r_s1.last_class || out_free);
    assign o_in_ready = !r_s1_vld || s1_go;
    assign in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_take) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1.class_score <= i_class_score;
            r_s1.center_x    <= i_center_x;
            r_s1.center_y    <= i_center_y;
            r_s1.box_width   <= i_box_width;
            r_s1.box_height  <= i_box_height;
            r_s1.last_class  <= i_last_class;
            r_s1.last_query  <= i_last_query;
        end
    end

    // ------------------------------------------------------------------
    // Running argmax
    // ------------------------------------------------------------------
    logic [dabd_pkg::SCORE_W-1:0] r_best_score;
    logic [dabd_pkg::LABEL_W-1:0] r_best_label;
    logic [dabd_pkg::LABEL_W-1:0] r_class_pos;
    logic                         take_new;
    logic [dabd_pkg::SCORE_W-1:0] n_best_score;
    logic [dabd_pkg::LABEL_W-1:0] n_best_label;
    logic                         kept;

    // First score of a query always wins; later ones only on a strict increase,
    // so ties keep the earlier class.
    assign take_new     = (r_class_pos == '0) || (r_s1.class_score > r_best_score);
    assign n_best_score = take_new ? r_s1.class_score : r_best_score;
    assign n_best_label = take_new ? r_class_pos : r_best_label;
    assign kept         = n_best_score >= r_score_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= '0;
            r_best_label <= '0;
            r_class_pos  <= '0;
        end else if (s1_go) begin
            if (r_s1.last_class) begin
                // close the query: start the next one fresh
                r_best_score <= '0;
                r_best_label <= '0;
                r_class_pos  <= '0;
            end else begin
                r_best_score <= n_best_score;
                r_best_label <= n_best_label;
                // hold at the last class once the query runs long
                if (r_class_pos < dabd_pkg::LAST_POS) begin
                    r_class_pos <= r_class_pos + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Corner decode: four independent scale-and-clip units
    // ------------------------------------------------------------------
    logic [dabd_pkg::COORD_W-1:0] left_px;
    logic [dabd_pkg::COORD_W-1:0] top_px;
    logic [dabd_pkg::COORD_W-1:0] right_px;
    logic [dabd_pkg::COORD_W-1:0] bottom_px;

    dabd_edge u_left (
        .i_centre (r_s1.center_x),
        .i_size   (r_s1.box_width),
        .i_near   (1'b1),
        .i_limit  (r_max_col),
        .i_scale  (r_pixels_per_unit),
        .o_px     (left_px)
    );

    dabd_edge u_top (
        .i_centre (r_s1.center_y),
        .i_size   (r_s1.box_height),
        .i_near   (1'b1),
        .i_limit  (r_max_row),
        .i_scale  (r_pixels_per_unit),
        .o_px     (top_px)
    );

    dabd_edge u_right (
        .i_centre (r_s1.center_x),
        .i_size   (r_s1.box_width),
        .i_near   (1'b0),
        .i_limit  (r_max_col),
        .i_scale  (r_pixels_per_unit),
        .o_px     (right_px)
    );

    dabd_edge u_bottom (
        .i_centre (r_s1.center_y),
        .i_size   (r_s1.box_height),
        .i_near   (1'b0),
        .i_limit  (r_max_row),
        .i_scale  (r_pixels_per_unit),
        .o_px     (bottom_px)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                         r_out_vld;
    logic                         out_load;
    logic                         r_kept;
    logic [dabd_pkg::LABEL_W-1:0] r_label;
    logic [dabd_pkg::SCORE_W-1:0] r_best_confidence;
    logic [dabd_pkg::COORD_W-1:0] r_left_px;
    logic [dabd_pkg::COORD_W-1:0] r_top_px;
    logic [dabd_pkg::COORD_W-1:0] r_right_px;
    logic [dabd_pkg::COORD_W-1:0] r_bottom_px;
    logic                         r_frame_done;

    assign out_load    = s1_go && r_s1.last_class;
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Dropped detections report label and score but zero corners.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kept            <= kept;
            r_label           <= n_best_label;
            r_best_confidence <= n_best_score;
            r_left_px         <= kept ? left_px   : '0;
            r_top_px          <= kept ? top_px    : '0;
            r_right_px        <= kept ? right_px  : '0;
            r_bottom_px       <= kept ? bottom_px : '0;
            r_frame_done      <= r_s1.last_query;
        end
    end

    assign o_kept            = r_kept;
    assign o_label           = r_label;
    assign o_best_confidence = r_best_confidence;
    assign o_left_px         = r_left_px;
    assign o_top_px          = r_top_px;
    assign o_right_px        = r_right_px;
    assign o_bottom_px       = r_bottom_px;
    assign o_frame_done      = r_frame_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_class_pos <= dabd_pkg::LAST_POS)
        else $error("class position beyond last class");

    a_drop_zero_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_kept) |-> (o_left_px == '0 && o_top_px == '0
                                      && o_right_px == '0 && o_bottom_px == '0))
        else $error("dropped detection carries a box");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kept) |-> (o_left_px <= o_right_px && o_top_px <= o_bottom_px))
        else $error("near edge beyond far edge");

    a_label_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_label <= dabd_pkg::LAST_POS))
        else $error("label out of class range");

endmodule

// ----- tb/sv/detection_argmax_box_decode_top_tb.sv -----
// Self-checking testbench for the streaming class argmax and box corner decoder.
module detection_argmax_box_decode_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 800000;

    // One detection word as the result port presents it
    typedef struct packed {
        logic                         kept;
        logic [dabd_pkg::LABEL_W-1:0] label;
        logic [dabd_pkg::SCORE_W-1:0] best_confidence;
        logic [dabd_pkg::COORD_W-1:0] left_px;
        logic [dabd_pkg::COORD_W-1:0] top_px;
        logic [dabd_pkg::COORD_W-1:0] right_px;
        logic [dabd_pkg::COORD_W-1:0] bottom_px;
        logic                         frame_done;
    } t_detection;

    // ------------------------------------------------------------------
    // Clock, reset and pins
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic                         in_valid  = 1'b0;
    logic                         o_in_ready;
    dabd_pkg::t_item              cur_word  = '0;
    logic                         out_ready = 1'b0;
    logic                         o_out_valid;
    logic                         o_kept;
    logic [dabd_pkg::LABEL_W-1:0] o_label;
    logic [dabd_pkg::SCORE_W-1:0] o_best_confidence;
    logic [dabd_pkg::COORD_W-1:0] o_left_px;
    logic [dabd_pkg::COORD_W-1:0] o_top_px;
    logic [dabd_pkg::COORD_W-1:0] o_right_px;
    logic [dabd_pkg::COORD_W-1:0] o_bottom_px;
    logic                         o_frame_done;

    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [dabd_pkg::PADDR_W-1:0] paddr   = '0;
    logic [dabd_pkg::PDATA_W-1:0] pwdata  = '0;
    logic [dabd_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    detection_argmax_box_decode_top i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_class_score     (cur_word.class_score),
        .i_center_x        (cur_word.center_x),
        .i_center_y        (cur_word.center_y),
        .i_box_width       (cur_word.box_width),
        .i_box_height      (cur_word.box_height),
        .i_last_class      (cur_word.last_class),
        .i_last_query      (cur_word.last_query),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_kept            (o_kept),
        .o_label           (o_label),
        .o_best_confidence (o_best_confidence),
        .o_left_px         (o_left_px),
        .o_top_px          (o_top_px),
        .o_right_px        (o_right_px),
        .o_bottom_px       (o_bottom_px),
        .o_frame_done      (o_frame_done),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // ------------------------------------------------------------------
    // Predictor: register copy and running argmax state
    // ------------------------------------------------------------------
    logic [dabd_pkg::COORD_W-1:0] px_scale  = dabd_pkg::RST_PIXELS_PER_UNIT;
    logic [dabd_pkg::LIMIT_W-1:0] col_limit = dabd_pkg::RST_MAX_COL;
    logic [dabd_pkg::LIMIT_W-1:0] row_limit = dabd_pkg::RST_MAX_ROW;
    logic [dabd_pkg::SCORE_W-1:0] keep_thr  = dabd_pkg::RST_SCORE_THRESHOLD;

    logic [dabd_pkg::SCORE_W-1:0] best_score = '0;
    logic [dabd_pkg::LABEL_W-1:0] best_label = '0;
    logic [dabd_pkg::LABEL_W-1:0] class_pos  = '0;

    t_detection      detections_due[$];
    dabd_pkg::t_item pending_words[$];

    int unsigned words_queued   = 0;
    int unsigned words_taken    = 0;
    int unsigned dets_seen      = 0;
    int unsigned dets_kept      = 0;
    int unsigned dets_dropped   = 0;
    int unsigned overlong_words = 0;
    int unsigned drains         = 0;
    int unsigned phases         = 0;
    int unsigned mismatches     = 0;
    int unsigned cycles         = 0;

    // Corner in Q12.4: edge = 2*centre -/+ size (units of 2^-17), scaled, truncated, clipped
    function automatic logic [dabd_pkg::COORD_W-1:0] corner_px(
        input logic [dabd_pkg::COORD_W-1:0] centre,
        input logic [dabd_pkg::COORD_W-1:0] size,
        input bit                           near,
        input logic [dabd_pkg::LIMIT_W-1:0] lim,
        input logic [dabd_pkg::COORD_W-1:0] scale);
        logic [17:0] twice;
        logic [17:0] span;
        logic [33:0] prod;
        logic [16:0] px;
        logic [16:0] cap;
        twice = {1'b0, centre, 1'b0};
        cap   = {1'b0, lim, 4'b0000};
        if (near) begin
            // a near edge at or left of zero clamps to zero
            if (twice <= {2'b00, size})
                return '0;
            span = twice - {2'b00, size};
        end else begin
            span = twice + {2'b00, size};
        end
        prod = {16'd0, span} * {18'd0, scale};
        px   = prod[33:17];
        if (px > cap)
            px = cap;
        return px[dabd_pkg::COORD_W-1:0];
    endfunction

    // Fold one accepted score word into the argmax; queue a detection when it closes a query
    task automatic absorb_word(input dabd_pkg::t_item w);
        t_detection d;
        if (class_pos == '0 || w.class_score > best_score) begin
            best_score = w.class_score;
            best_label = class_pos;
        end
        if (!w.last_class) begin
            // past the last class the position sticks and later scores compete under it
            if (class_pos < dabd_pkg::LAST_POS)
                class_pos++;
            else
                overlong_words++;
            return;
        end
        d.kept            = (best_score >= keep_thr);
        d.label           = best_label;
        d.best_confidence = best_score;
        d.left_px         = '0;
        d.top_px          = '0;
        d.right_px        = '0;
        d.bottom_px       = '0;
        if (d.kept) begin
            d.left_px   = corner_px(w.center_x, w.box_width,  1'b1, col_limit, px_scale);
            d.top_px    = corner_px(w.center_y, w.box_height, 1'b1, row_limit, px_scale);
            d.right_px  = corner_px(w.center_x, w.box_width,  1'b0, col_limit, px_scale);
            d.bottom_px = corner_px(w.center_y, w.box_height, 1'b0, row_limit, px_scale);
            dets_kept++;
        end else begin
            dets_dropped++;
        end
        d.frame_done = w.last_query;
        detections_due = {detections_due, d};
        best_score = '0;
        best_label = '0;
        class_pos  = '0;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Most idle stretches are short, a few are long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check result words first, then predict from accepted score words
    // ------------------------------------------------------------------
    logic in_fire = 1'b0;

    always @(posedge clk) begin
        t_detection want;
        if (!rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (detections_due.size() == 0) begin
                    $error("result word arrived with no detection pending");
                    mismatches++;
                end else begin
                    want = detections_due.pop_front();
                    check_field("kept", 16'(want.kept), 16'(o_kept));
                    check_field("label", 16'(want.label), 16'(o_label));
                    check_field("best_confidence", want.best_confidence, o_best_confidence);
                    check_field("left_px",         want.left_px,         o_left_px);
                    check_field("top_px",          want.top_px,          o_top_px);
                    check_field("right_px",        want.right_px,        o_right_px);
                    check_field("bottom_px",       want.bottom_px,       o_bottom_px);
                    check_field("frame_done", 16'(want.frame_done), 16'(o_frame_done));
                    dets_seen++;
                end
            end
            if (in_valid && o_in_ready) begin
                absorb_word(cur_word);
                words_taken++;
            end
            in_fire <= in_valid && o_in_ready;
        end
    end

    // ------------------------------------------------------------------
    // Score word driver: pop pending words at the falling edge, with gaps
    // ------------------------------------------------------------------
    int unsigned gap_left   = 0;
    int unsigned quiet_left = 0;
    int unsigned driven     = 0;
    bit          drain_wait = 1'b0;

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fire) begin
            // hold the word until it is taken
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
        end else if (drain_wait && detections_due.size() != 0) begin
            // hold off until every detection in flight has come out
            in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
            cur_word <= pending_words.pop_front();
            in_valid <= 1'b1;
            driven++;
            drain_wait = (driven % 400 == 200) || ($urandom_range(0, 199) == 0);
            if (drain_wait)
                drains++;
            if (quiet_left > 0) begin
                quiet_left--;
                gap_left = 0;
            end else begin
                gap_left = idle_len();
                if ($urandom_range(0, 99) == 0)
                    quiet_left = $urandom_range(40, 160);
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, with stall-free stretches
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned calm_left  = 0;

    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            if (calm_left > 0) begin
                calm_left--;
            end else begin
                stall_left = idle_len();
                if ($urandom_range(0, 99) == 0)
                    calm_left = $urandom_range(40, 160);
            end
        end
    end

    // Watchdog: a run that stops making progress fails here
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("detection_argmax_box_decode_top_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic dabd_pkg::t_item make_word(input logic [15:0] score,
                                                  input logic [15:0] cx,
                                                  input logic [15:0] cy,
                                                  input logic [15:0] bw,
                                                  input logic [15:0] bh, input logic lc,
                                                  input logic lq);
        dabd_pkg::t_item w;
        w.class_score = score;
        w.center_x    = cx;
        w.center_y    = cy;
        w.box_width   = bw;
        w.box_height  = bh;
        w.last_class  = lc;
        w.last_query  = lq;
        return w;
    endfunction

    task automatic queue_word(input dabd_pkg::t_item w);
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    // Favor the extremes, ties with the previous score and the exact threshold
    function automatic logic [15:0] pick_score(input logic [15:0] prev);
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return prev;
            3:       return keep_thr;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One query: mostly short, some at or near full length, a few running past the class count
    task automatic add_query();
        int          len;
        int          r;
        logic [15:0] prev;
        logic        lc;
        logic        lq;
        r    = $urandom_range(0, 99);
        prev = '0;
        if (r < 60)
            len = $urandom_range(1, 6);
        else if (r < 85)
            len = $urandom_range(7, 30);
        else if (r < 95)
            len = $urandom_range(dabd_pkg::NUM_CLASSES - 10, dabd_pkg::NUM_CLASSES);
        else
            len = $urandom_range(dabd_pkg::NUM_CLASSES + 1, dabd_pkg::NUM_CLASSES + 20);
        for (int i = 0; i < len; i++) begin
            lc   = (i == len - 1);
            // a stray last_query on an inner word is noise the block must ignore
            lq   = lc ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) == 0);
            prev = pick_score(prev);
            queue_word(make_word(prev, pick_coord(), pick_coord(), pick_coord(),
                                 pick_coord(), lc, lq));
        end
    endtask

    // Wait until every queued word is taken and every detection has come out
    task automatic wait_idle();
        @(negedge clk);
        while (words_taken != words_queued || detections_due.size() != 0)
            @(negedge clk);
        // let a query left open settle in the pipeline
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [dabd_pkg::PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            dabd_pkg::REG_PIXELS_PER_UNIT: px_scale  = value[dabd_pkg::COORD_W-1:0];
            dabd_pkg::REG_MAX_COL:         col_limit = value[dabd_pkg::LIMIT_W-1:0];
            dabd_pkg::REG_MAX_ROW:         row_limit = value[dabd_pkg::LIMIT_W-1:0];
            dabd_pkg::REG_SCORE_THRESHOLD: keep_thr  = value[dabd_pkg::SCORE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain, rewrite every register, then stream random queries
    task automatic run_phase(input logic [15:0] scale, input logic [11:0] mc,
                             input logic [11:0] mr, input logic [15:0] thr,
                             input int unsigned n);
        int unsigned start;
        wait_idle();
        write_reg(dabd_pkg::REG_PIXELS_PER_UNIT, {16'd0, scale});
        write_reg(dabd_pkg::REG_MAX_COL,         {20'd0, mc});
        write_reg(dabd_pkg::REG_MAX_ROW,         {20'd0, mr});
        write_reg(dabd_pkg::REG_SCORE_THRESHOLD, {16'd0, thr});
        phases++;
        start = words_queued;
        while (words_queued - start < n)
            add_query();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed queries under the reset register values.
        // Tie on the top score keeps the earlier class; near edge below zero.
        queue_word(make_word(16'd100,   16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        queue_word(make_word(16'hFFFF,  16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        queue_word(make_word(16'hFFFF,  16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        queue_word(make_word(16'd7,     16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        // Single-class query at exactly the threshold; near edge lands exactly on zero
        queue_word(make_word(16'd32768, 16'd1000, 16'd32768, 16'd2000, 16'd0, 1'b1, 1'b0));
        // Just below threshold: dropped, corners zero, frame end reported
        queue_word(make_word(16'd32767, 16'h1234, 16'h5678, 16'h0100, 16'h0200, 1'b1, 1'b1));
        // All-zero scores: class zero wins
        queue_word(make_word(16'd0,     16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        queue_word(make_word(16'd0,     16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        queue_word(make_word(16'd0,     16'h8000, 16'h8000, 16'h4000, 16'h4000, 1'b1, 1'b0));
        // last_query on a non-closing word is ignored
        queue_word(make_word(16'd50000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
        queue_word(make_word(16'd40000, 16'h4000, 16'hC000, 16'h2000, 16'h6000, 1'b1, 1'b0));
        // Best class last; far edges hit the clip limit
        queue_word(make_word(16'd1,     16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        queue_word(make_word(16'd2,     16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        queue_word(make_word(16'd3,     16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
        queue_word(make_word(16'hFFFF,  16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1, 1'b1));

        // Random phases, extremes of every register among them
        run_phase(16'hFFFF, 12'd4095, 12'd4095, 16'd0,     300);
        run_phase(16'd0,    12'd0,    12'd0,    16'hFFFF,  200);
        run_phase(16'd16,   12'd4095, 12'd0,    16'd1,     300);
        run_phase(16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)), 350);
        run_phase(16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)), 350);
        run_phase(16'd10240, 12'd639, 12'd479, 16'd49152,  300);

        wait_idle();
        repeat (8) @(negedge clk);

        $display("covered %0d score words and %0d detections (%0d kept, %0d dropped)",
                 words_taken, dets_seen, dets_kept, dets_dropped);
        $display("over %0d register settings, %0d words past the class count, %0d drains",
                 phases + 1, overlong_words, drains);
        if (mismatches == 0 && detections_due.size() == 0) begin
            $display("detection_argmax_box_decode_top_tb passed");
        end else begin
            $display("detection_argmax_box_decode_top_tb failed");
        end
        $finish;
    end

endmodule

// ----- detection_argmax_box_decode_top.f -----
src/dabd_pkg.sv
src/dabd_edge.sv
src/detection_argmax_box_decode_top.sv
tb/sv/detection_argmax_box_decode_top_tb.sv
